// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/bfu_pkg.sv
`timescale 1ns / 1ps
package bfu_pkg;

    localparam int HASH_W      = 32;
    localparam int NUM_HASH    = 5;
    localparam int HASH_BITS   = HASH_W * NUM_HASH;
    localparam int NUM_SHIFTS  = 4;
    localparam int NUM_PROBES  = NUM_SHIFTS * NUM_HASH;
    localparam int PROBE_W     = 5;
    localparam int IDX_W       = 64;
    localparam int BIT_SEL_W   = 6;
    localparam int DIV_STEPS   = IDX_W - BIT_SEL_W;
    localparam int DIV_CNT_W   = 6;
    localparam int WIU_W       = 17;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam logic [WIU_W-1:0] WIU_RESET = 17'h10000;
    localparam logic REG_WORDS_IN_USE = 1'b0;

    localparam int PROBE_SHIFT [NUM_SHIFTS] = '{24, 28, 36, 40};

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_INIT  = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_CHK   = 9'b000100000,
        ST_SRD   = 9'b001000000,
        ST_SWR   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic div_init;
        logic div_step;
        logic rd_issue;
        logic chk;
        logic set_wr;
        logic next_probe;
        logic probe_rst;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic probe_last;
        logic insert;
    } dp_stat_t;

endpackage

// File: rtl/bloom_filter_160bit_unit.sv
// Per probe: setup, 58 remainder steps, read, check; an insert's result comes after
//   a query's would, following a set pass that reads and writes each probe's word.
// Throughput: one item at a time; the 58-step remainder unit sets the pace.
// Reset: synchronous, active low; afterwards the bit store is zeroed one word per
//   cycle and s_tready stays low until that pass completes.
`timescale 1ns / 1ps
module bloom_filter_160bit_unit #(
    parameter int MAX_WORDS = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfu_pkg::APB_AW-1:0]    paddr,
    input  logic [bfu_pkg::APB_DW-1:0]    pwdata,
    output logic [bfu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // Input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bfu_pkg::HASH_BITS-1:0] s_tdata,  // hash_word0 .. hash_word4
    input  logic                          s_tuser,  // cmd (0 query, 1 insert)
    // Result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata   // present, zero fill
);
    import bfu_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WW = $clog2(MAX_WORDS + 1);

    logic [WIU_W-1:0] words_in_use_reg;
    logic             cfg_wr;
    logic             present;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // Register file: a single word-count register at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_in_use_reg <= WIU_RESET;
        end else if (cfg_wr && (paddr[2] == REG_WORDS_IN_USE)) begin
            words_in_use_reg <= pwdata[WIU_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_WORDS_IN_USE) ? APB_DW'(words_in_use_reg) : '0;

    // Sequencer: clear pass, then per probe remainder, lookup, and on insert a set pass.
    bfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Index generation, remainder unit, bit store and result register.
    bfu_datapath #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW),
        .WW        (WW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .hash_in      (s_tdata),
        .insert_in    (s_tuser),
        .words_in_use (words_in_use_reg),
        .present_out  (present)
    );

    assign m_tdata = {7'b0, present};

endmodule

// File: rtl/bfu_datapath.sv
`timescale 1ns / 1ps
module bfu_datapath #(
    parameter int MAX_WORDS = 65536,
    parameter int AW        = 16,
    parameter int WW        = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bfu_pkg::dp_cmd_t              cmd,
    output bfu_pkg::dp_stat_t             stat,
    input  logic [bfu_pkg::HASH_BITS-1:0] hash_in,
    input  logic                          insert_in,
    input  logic [bfu_pkg::WIU_W-1:0]     words_in_use,
    output logic                          present_out
);
    import bfu_pkg::*;

    localparam int CW = (WW > WIU_W) ? WW : WIU_W;
    localparam int RW = WW + 1;

    logic [HASH_W-1:0]    w_reg [NUM_HASH];
    logic                 insert_reg;
    logic [WW-1:0]        eff_words_reg;
    logic [PROBE_W-1:0]   probe_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_STEPS-1:0] dvd_reg;
    logic [RW-1:0]        rem_reg;
    logic [AW-1:0]        addr_arr_reg [NUM_PROBES];
    logic [BIT_SEL_W-1:0] bit_arr_reg  [NUM_PROBES];
    logic [AW-1:0]        clr_addr_reg;
    logic [IDX_W-1:0]     rdata_reg;
    logic                 present_acc_reg;
    logic                 out_present_reg;
    logic [IDX_W-1:0]     mem [MAX_WORDS];

    logic [IDX_W-1:0]     pair [NUM_HASH];
    logic [IDX_W-1:0]     lane [NUM_PROBES];
    logic [IDX_W-1:0]     idx_cur;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        rem_next;
    logic [CW-1:0]        wiu_ext;
    logic [WW-1:0]        eff_words_next;
    logic [AW-1:0]        mem_addr;
    logic [AW-1:0]        probe_addr;
    logic [BIT_SEL_W-1:0] probe_bit;

    assign pair[0] = {w_reg[0], w_reg[1]};
    assign pair[1] = {w_reg[2], w_reg[3]};
    assign pair[2] = {w_reg[4], w_reg[0]};
    assign pair[3] = {w_reg[1], w_reg[2]};
    assign pair[4] = {w_reg[3], w_reg[4]};

    // One fixed shift-or lane per probe.
    for (genvar i = 0; i < NUM_PROBES; i++) begin : g_lane
        localparam int S = PROBE_SHIFT[i / NUM_HASH];
        localparam int K = i % NUM_HASH;
        localparam int KN = (K + 1) % NUM_HASH;
        assign lane[i] = (pair[K] << S) | (pair[KN] >> S);
    end

    assign idx_cur    = lane[probe_reg];
    assign probe_addr = addr_arr_reg[probe_reg];
    assign probe_bit  = bit_arr_reg[probe_reg];

    // Restoring remainder step: one dividend bit per cycle.
    assign rem_sh   = {rem_reg[RW-2:0], dvd_reg[DIV_STEPS-1]};
    assign rem_next = (rem_sh >= RW'(eff_words_reg)) ? rem_sh - RW'(eff_words_reg) : rem_sh;

    // Clamp word count to 1..MAX_WORDS.
    assign wiu_ext = CW'(words_in_use);
    always_comb begin
        if (wiu_ext == '0) begin
            eff_words_next = WW'(1);
        end else if (wiu_ext > CW'(MAX_WORDS)) begin
            eff_words_next = WW'(MAX_WORDS);
        end else begin
            eff_words_next = WW'(wiu_ext);
        end
    end

    assign mem_addr = cmd.clear_step ? clr_addr_reg : probe_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            probe_reg    <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load || cmd.probe_rst) begin
                probe_reg <= '0;
            end else if (cmd.next_probe) begin
                probe_reg <= probe_reg + PROBE_W'(1);
            end
            if (cmd.div_init) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int j = 0; j < NUM_HASH; j++) begin
                w_reg[j] <= hash_in[j*HASH_W +: HASH_W];
            end
            insert_reg      <= insert_in;
            eff_words_reg   <= eff_words_next;
            present_acc_reg <= 1'b1;
        end
        if (cmd.div_init) begin
            dvd_reg                 <= idx_cur[IDX_W-1:BIT_SEL_W];
            rem_reg                 <= '0;
            bit_arr_reg[probe_reg]  <= idx_cur[BIT_SEL_W-1:0];
        end
        if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DIV_STEPS-2:0], 1'b0};
            rem_reg <= rem_next;
            if (stat.div_last) begin
                addr_arr_reg[probe_reg] <= rem_next[AW-1:0];
            end
        end
        if (cmd.chk) begin
            present_acc_reg <= present_acc_reg & rdata_reg[probe_bit];
        end
        if (cmd.out_load) begin
            out_present_reg <= present_acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rdata_reg <= mem[mem_addr];
        end
        if (cmd.clear_step) begin
            mem[mem_addr] <= '0;
        end else if (cmd.set_wr) begin
            mem[mem_addr] <= rdata_reg | (IDX_W'(1) << probe_bit);
        end
    end

    assign stat.clear_last = (clr_addr_reg == AW'(MAX_WORDS - 1));
    assign stat.div_last   = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.probe_last = (probe_reg == PROBE_W'(NUM_PROBES - 1));
    assign stat.insert     = insert_reg;
    assign present_out     = out_present_reg;

endmodule

// File: rtl/bfu_ctrl.sv
`timescale 1ns / 1ps
module bfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bfu_pkg::dp_cmd_t  cmd,
    input  bfu_pkg::dp_stat_t stat
);
    import bfu_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = ST_RD;
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk = 1'b1;
                if (!stat.probe_last) begin
                    cmd.next_probe = 1'b1;
                    state_next     = ST_INIT;
                end else if (stat.insert) begin
                    cmd.probe_rst = 1'b1;
                    state_next    = ST_SRD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SRD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SWR;
            end
            ST_SWR: begin
                cmd.set_wr = 1'b1;
                if (stat.probe_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.next_probe = 1'b1;
                    state_next     = ST_SRD;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/bfu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // Result beat holds while stalled.
    `ASSERT_CLK(a_m_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "m_tvalid dropped")
    `ASSERT_CLK(a_m_stable, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "m_tdata changed")
    // Reset starts the clear pass, so no input is taken right after it.
    `ASSERT_CLK_NR(a_rst_busy, aclk, !aresetn |=> !s_tready, "ready during clear pass")
    // One item in flight: an accepted beat closes the input.
    `ASSERT_CLK(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second item taken")
endmodule

bind bloom_filter_160bit_unit bfu_checker u_bfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bfu_pkg::*;

    localparam int FILTER_DEPTH = 65536;
    localparam int SHIFTS [4] = '{24, 28, 36, 40};

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [HASH_BITS-1:0] s_tdata;   // hash_word0 .. hash_word4, word0 lowest
    logic                 s_tuser;   // cmd: 0 query, 1 insert
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // present, then zero fill

    // Mirror of the filter: bit store and the word-count register.
    bit [63:0]        filter_words [FILTER_DEPTH];
    bit [WIU_W-1:0]   words_reg;
    bit [7:0]         presence_queue [$];
    bit [159:0]       inserted_hashes [$];
    bit               steady_flow;
    int               error_count;

    bloom_filter_160bit_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run 20 probes against the mirror; return prior membership and set bits on insert.
    function automatic bit probe_filter(bit is_insert, bit [159:0] hash);
        bit [31:0]  w [5];
        bit [63:0]  a [5];
        bit [63:0]  nbits;
        bit [63:0]  rem;
        bit [63:0]  word_cnt;
        bit [63:0]  idx;
        int         word_sel [20];
        int         bit_sel [20];
        bit         all_set;
        all_set = 1'b1;
        for (int i = 0; i < 5; i++) w[i] = hash[32*i +: 32];
        a[0] = {w[0], w[1]};
        a[1] = {w[2], w[3]};
        a[2] = {w[4], w[0]};
        a[3] = {w[1], w[2]};
        a[4] = {w[3], w[4]};
        // Zero words counts as one; anything past the store saturates.
        word_cnt = words_reg;
        if (word_cnt == 0) word_cnt = 1;
        if (word_cnt > FILTER_DEPTH) word_cnt = FILTER_DEPTH;
        nbits = word_cnt * 64;
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < 5; k++) begin
                idx = (a[k] << SHIFTS[s]) | (a[(k + 1) % 5] >> SHIFTS[s]);
                rem = idx % nbits;
                word_sel[s*5 + k] = int'(rem >> 6);
                bit_sel[s*5 + k]  = int'(rem[5:0]);
                if (!filter_words[word_sel[s*5 + k]][bit_sel[s*5 + k]]) all_set = 1'b0;
            end
        end
        if (is_insert) begin
            for (int i = 0; i < 20; i++) filter_words[word_sel[i]][bit_sel[i]] = 1'b1;
        end
        return all_set;
    endfunction

    // Send one beat; hold valid across back-to-back beats, drop it only while idling.
    task automatic send_item(bit is_insert, bit [159:0] hash);
        while (!steady_flow && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hash;
        s_tuser  <= is_insert;
        do @(posedge aclk); while (!s_tready);
        presence_queue.push_back({7'b0, probe_filter(is_insert, hash)});
        if (is_insert) inserted_hashes.push_back(hash);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Let every outstanding result drain, then keep the inputs idle before going on.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (presence_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Setup beat then access beat; the register updates on the access edge.
    task automatic apb_write(int reg_index, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(reg_index * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == int'(REG_WORDS_IN_USE)) words_reg = value[WIU_W-1:0];
    endtask

    function automatic bit [159:0] random_hash();
        bit [159:0] h;
        for (int i = 0; i < 5; i++) h[32*i +: 32] = $urandom;
        return h;
    endfunction

    // Directed corners at the reset word count: zero and all-ones hashes,
    // query before and after insert, single walking bits.
    task automatic test_directed();
        bit [159:0] h;
        send_item(1'b0, '0);
        send_item(1'b1, '0);
        send_item(1'b0, '0);
        send_item(1'b1, '0);
        send_item(1'b0, '1);
        send_item(1'b1, '1);
        send_item(1'b0, '1);
        for (int i = 0; i < 5; i++) begin
            h = '0;
            h[32*i] = 1'b1;
            send_item(1'b1, h);
            h = '1;
            h[32*i + 31] = 1'b0;
            send_item(1'b0, h);
        end
        h = random_hash();
        send_item(1'b1, h);
        send_item(1'b0, h);
        wait_drained();
    endtask

    // A write to the unused register slot must leave the word count alone.
    task automatic test_unused_register();
        apb_write(1, 32'h5);
        send_item(1'b0, '1);
        send_item(1'b1, random_hash());
        wait_drained();
    endtask

    // Repeats of inserted hashes so queries hit, some all-zero or all-ones; mostly fresh noise.
    task automatic test_random_traffic(bit [31:0] words, int count);
        int         pick;
        bit [159:0] h;
        apb_write(int'(REG_WORDS_IN_USE), words);
        for (int n = 0; n < count; n++) begin
            steady_flow = (n >= count / 3 && n < count / 2);
            pick = $urandom_range(99);
            if (pick < 40 && inserted_hashes.size() != 0)
                h = inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
            else if (pick < 45)
                h = $urandom_range(1) ? '1 : '0;
            else
                h = random_hash();
            send_item($urandom_range(1), h);
            // Hold off now and then until the pipe is empty.
            if ($urandom_range(99) < 3) wait_drained();
        end
        steady_flow = 1'b0;
        wait_drained();
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (presence_queue.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                if (m_tdata !== presence_queue[0]) begin
                    $display("%0t: present mismatch, expected %h actual %h",
                             $time, presence_queue[0], m_tdata);
                    error_count++;
                end
                void'(presence_queue.pop_front());
            end
        end
    end

    // Stall the result side at random except during steady stretches.
    always @(posedge aclk) begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 38);
    end

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        steady_flow = 1'b0;
        error_count = 0;
        words_reg   = WIU_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_unused_register();
        test_random_traffic(32'd1, 90);
        test_random_traffic(32'd0, 80);
        test_random_traffic(32'd2, 90);
        test_random_traffic(32'd3, 80);
        test_random_traffic($urandom_range(4, 64), 90);
        test_random_traffic(32'd65536, 90);
        test_random_traffic(32'd100000, 70);
        test_random_traffic(32'h1FFFF, 70);
        test_random_traffic($urandom, 50);

        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog: sized for the clearing pass plus the per-beat processing, several times over.
    initial begin
        #(64'd150_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfu_pkg.sv
rtl/bfu_datapath.sv
rtl/bfu_ctrl.sv
rtl/bloom_filter_160bit_unit.sv
rtl/bfu_checker.sv
tb/tb_top.sv
